// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and search functions of the block bitmap allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MAP_BYTES = 1024;
  localparam int IDX_W     = 13;
  localparam int OP_W      = 2;

  // The summary memory holds one nonzero flag per map byte, 32 to a word.
  localparam int SUM_W    = 32;
  localparam int POS_W    = $clog2(SUM_W);
  localparam int NGROUPS  = (MAP_BYTES + SUM_W - 1) / SUM_W;
  localparam int GRP_AW   = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int BYTE_AW  = GRP_AW + POS_W;
  localparam int CLR_W    = $clog2(MAP_BYTES + 1);

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RESERVE = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [IDX_W-1:0] block_index;
  } bba_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    logic             status;
  } bba_res_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_SUM_WAIT,
    ST_MAP_WAIT
  } bba_state_e;

  function automatic logic [2:0] first_bit8(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] first_bit_sum(input logic [SUM_W-1:0] v);
    logic [POS_W-1:0] r;
    r = '0;
    for (int i = SUM_W - 1; i >= 0; i--) begin
      if (v[i]) r = POS_W'(i);
    end
    return r;
  endfunction

  function automatic logic [GRP_AW-1:0] first_grp(input logic [NGROUPS-1:0] v);
    logic [GRP_AW-1:0] r;
    r = '0;
    for (int i = NGROUPS - 1; i >= 0; i--) begin
      if (v[i]) r = GRP_AW'(i);
    end
    return r;
  endfunction

  // Summary word after reset: a one for every byte of the group inside the map.
  function automatic logic [SUM_W-1:0] grp_init_word(input logic [CLR_W-1:0] g);
    logic [SUM_W-1:0] w;
    for (int j = 0; j < SUM_W; j++) begin
      w[j] = ((int'(g) * SUM_W + j) < MAP_BYTES);
    end
    return w;
  endfunction

endpackage

// ===== rtl/block_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// First-fit free-block bitmap allocator with allocate, reserve and free.
// ----------------------------------------------------------------------------
// From an accepted request to its registered result strobe: an allocate
// that succeeds takes a summary read, a map read and a write-back; an in-range
// reserve or free takes a map read and a write-back; a full map, an unused opcode
// or a block beyond the map gets its result straight from idle. A new request is
// taken in the cycle its predecessor's result is shown. After reset a clearing
// pass writes ones to all MAP_BYTES (1024) map bytes while busy is high.
module block_bitmap_allocator import bba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  bba_req_t req_i,
  output logic     busy,
  output logic     res_valid_o,
  output bba_res_t res_o
);

  logic               map_re, map_we;
  logic [BYTE_AW-1:0] map_raddr, map_waddr;
  logic [7:0]         map_rdata, map_wdata;
  logic               sum_re, sum_we;
  logic [GRP_AW-1:0]  sum_raddr, sum_waddr;
  logic [SUM_W-1:0]   sum_rdata, sum_wdata;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req_i),
    .busy_o      (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .map_re_o    (map_re),
    .map_raddr_o (map_raddr),
    .map_rdata_i (map_rdata),
    .map_we_o    (map_we),
    .map_waddr_o (map_waddr),
    .map_wdata_o (map_wdata),
    .sum_re_o    (sum_re),
    .sum_raddr_o (sum_raddr),
    .sum_rdata_i (sum_rdata),
    .sum_we_o    (sum_we),
    .sum_waddr_o (sum_waddr),
    .sum_wdata_o (sum_wdata)
  );

  bba_ram #(
    .WIDTH (8),
    .DEPTH (MAP_BYTES),
    .AW    (BYTE_AW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata)
  );

  bba_ram #(
    .WIDTH (SUM_W),
    .DEPTH (NGROUPS),
    .AW    (GRP_AW)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .re_i    (sum_re),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata)
  );

endmodule

// ===== rtl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Generic synchronous RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Request sequencer: clearing pass, first-fit search and read-modify-write.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  bba_req_t           req_i,
  output logic               busy_o,
  output logic               res_valid_o,
  output bba_res_t           res_o,
  output logic               map_re_o,
  output logic [BYTE_AW-1:0] map_raddr_o,
  input  logic [7:0]         map_rdata_i,
  output logic               map_we_o,
  output logic [BYTE_AW-1:0] map_waddr_o,
  output logic [7:0]         map_wdata_o,
  output logic               sum_re_o,
  output logic [GRP_AW-1:0]  sum_raddr_o,
  input  logic [SUM_W-1:0]   sum_rdata_i,
  output logic               sum_we_o,
  output logic [GRP_AW-1:0]  sum_waddr_o,
  output logic [SUM_W-1:0]   sum_wdata_o
);

  bba_state_e state_q, state_d;
  logic [CLR_W-1:0]   clr_q, clr_d;
  logic [NGROUPS-1:0] group_q, group_d;
  logic               res_valid_q, res_valid_d;
  bba_res_t           res_q, res_d;
  logic [OP_W-1:0]    op_q, op_d;
  logic [IDX_W-1:0]   blk_q, blk_d;
  logic [GRP_AW-1:0]  grp_q, grp_d;
  logic [POS_W-1:0]   pos_q, pos_d;

  logic               in_range;
  logic [BYTE_AW-1:0] req_byte;
  logic [2:0]         take_bit;
  logic [7:0]         new_byte;
  logic [SUM_W-1:0]   new_sum;
  logic [POS_W-1:0]   sum_pos;

  assign in_range = (int'(req_i.block_index[IDX_W-1:3]) < MAP_BYTES);
  assign req_byte = BYTE_AW'(req_i.block_index[IDX_W-1:3]);
  assign take_bit = first_bit8(map_rdata_i);
  assign sum_pos  = first_bit_sum(sum_rdata_i);

  // Modified byte and summary word during the write-back cycle.
  always_comb begin
    new_byte = map_rdata_i;
    case (op_q)
      OP_ALLOC:   new_byte[take_bit] = 1'b0;
      OP_RESERVE: new_byte[blk_q[2:0]] = 1'b0;
      OP_FREE:    new_byte[blk_q[2:0]] = 1'b1;
      default:    new_byte = map_rdata_i;
    endcase
    new_sum = sum_rdata_i;
    new_sum[pos_q] = |new_byte;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (int'(clr_q) == MAP_BYTES - 1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          case (req_i.opcode)
            OP_ALLOC: begin
              if (|group_q) state_d = ST_SUM_WAIT;
            end
            OP_RESERVE, OP_FREE: begin
              if (in_range) state_d = ST_MAP_WAIT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SUM_WAIT: state_d = ST_MAP_WAIT;
      ST_MAP_WAIT: state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_d       = clr_q;
    group_d     = group_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    op_d        = op_q;
    blk_d       = blk_q;
    grp_d       = grp_q;
    pos_d       = pos_q;
    map_re_o    = 1'b0;
    map_raddr_o = {grp_q, pos_q};
    map_we_o    = 1'b0;
    map_waddr_o = {grp_q, pos_q};
    map_wdata_o = new_byte;
    sum_re_o    = 1'b0;
    sum_raddr_o = grp_q;
    sum_we_o    = 1'b0;
    sum_waddr_o = grp_q;
    sum_wdata_o = new_sum;
    unique case (state_q)
      ST_INIT: begin
        clr_d       = clr_q + 1'b1;
        map_we_o    = 1'b1;
        map_waddr_o = BYTE_AW'(clr_q);
        map_wdata_o = 8'hFF;
        sum_we_o    = (int'(clr_q) < NGROUPS);
        sum_waddr_o = GRP_AW'(clr_q);
        sum_wdata_o = grp_init_word(clr_q);
      end
      ST_IDLE: begin
        if (start_i) begin
          op_d  = req_i.opcode;
          blk_d = req_i.block_index;
          case (req_i.opcode)
            OP_ALLOC: begin
              if (|group_q) begin
                grp_d       = first_grp(group_q);
                sum_re_o    = 1'b1;
                sum_raddr_o = first_grp(group_q);
              end else begin
                res_valid_d        = 1'b1;
                res_d.result_index = '0;
                res_d.status       = 1'b1;
              end
            end
            OP_RESERVE, OP_FREE: begin
              if (in_range) begin
                grp_d       = req_byte[BYTE_AW-1:POS_W];
                pos_d       = req_byte[POS_W-1:0];
                map_re_o    = 1'b1;
                map_raddr_o = req_byte;
                sum_re_o    = 1'b1;
                sum_raddr_o = req_byte[BYTE_AW-1:POS_W];
              end else begin
                res_valid_d        = 1'b1;
                res_d.result_index = req_i.block_index;
                res_d.status       = 1'b0;
              end
            end
            default: begin
              res_valid_d        = 1'b1;
              res_d.result_index = req_i.block_index;
              res_d.status       = 1'b0;
            end
          endcase
        end
      end
      ST_SUM_WAIT: begin
        // The summary read data stays put until the write-back cycle.
        pos_d       = sum_pos;
        map_re_o    = 1'b1;
        map_raddr_o = {grp_q, sum_pos};
      end
      ST_MAP_WAIT: begin
        map_we_o         = 1'b1;
        sum_we_o         = 1'b1;
        group_d[grp_q]   = |new_sum;
        res_valid_d      = 1'b1;
        res_d.status     = 1'b0;
        if (op_q == OP_ALLOC) begin
          res_d.result_index = IDX_W'({grp_q, pos_q, take_bit});
        end else begin
          res_d.result_index = blk_q;
        end
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_q       <= '0;
      group_q     <= '1;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      group_q     <= group_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    op_q  <= op_d;
    blk_q <= blk_d;
    grp_q <= grp_d;
    pos_q <= pos_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== tb/bba_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bba_result_checker
// Watches the request and result channels of the block bitmap allocator,
// keeps its own copy of the free map to predict every result, and compares
// each result strobe with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module bba_result_checker import bba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  bba_req_t req_i,
  input  logic     busy,
  input  logic     res_valid_o,
  input  bba_res_t res_o,
  output int       mismatch_count,
  output int       outstanding
);

  logic [7:0] free_map [MAP_BYTES];
  // Every byte below scan_floor is known to be all zeros.
  int         scan_floor;
  bba_res_t   predicted_results [$];
  bba_res_t   oldest;
  int         errors;

  initial begin
    for (int i = 0; i < MAP_BYTES; i++) begin
      free_map[i] = 8'hFF;
    end
    scan_floor     = 0;
    errors         = 0;
    mismatch_count = 0;
    outstanding    = 0;
  end

  // Applies one request to the local map and returns the result it causes.
  function automatic bba_res_t map_request(input bba_req_t rq);
    int       byte_no;
    int       bit_no;
    int       i;
    int       b;
    bba_res_t rs;
    rs.result_index = rq.block_index;
    rs.status       = 1'b0;
    byte_no         = int'(rq.block_index) >> 3;
    bit_no          = int'(rq.block_index[2:0]);
    case (rq.opcode)
      OP_ALLOC: begin
        i = scan_floor;
        while (i < MAP_BYTES && free_map[i] == 8'h00) i++;
        scan_floor = i;
        if (i >= MAP_BYTES) begin
          rs.result_index = '0;
          rs.status       = 1'b1;
        end else begin
          b = 0;
          while (b < 7 && !free_map[i][b]) b++;
          free_map[i][b]  = 1'b0;
          rs.result_index = IDX_W'(i * 8 + b);
        end
      end
      OP_RESERVE: begin
        if (byte_no < MAP_BYTES) free_map[byte_no][bit_no] = 1'b0;
      end
      OP_FREE: begin
        if (byte_no < MAP_BYTES) begin
          free_map[byte_no][bit_no] = 1'b1;
          if (byte_no < scan_floor) scan_floor = byte_no;
        end
      end
      default: begin
      end
    endcase
    return rs;
  endfunction

  task automatic report_mismatch(input string field, input int expected, input int actual);
    errors++;
    $error("%s: expected %0d, got %0d", field, expected, actual);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // The result of an older request is retired before a new one is queued.
      if (res_valid_o) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unrequested result_index", -1, int'(res_o.result_index));
        end else begin
          oldest = predicted_results.pop_front();
          if (res_o.result_index !== oldest.result_index) begin
            report_mismatch("result_index", int'(oldest.result_index),
                            int'(res_o.result_index));
          end
          if (res_o.status !== oldest.status) begin
            report_mismatch("status", int'(oldest.status), int'(res_o.status));
          end
        end
      end
      if (start && !busy) begin
        predicted_results.push_back(map_request(req_i));
      end
    end
    mismatch_count <= errors;
    outstanding    <= predicted_results.size();
  end

endmodule

// ===== tb/block_bitmap_allocator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_bitmap_allocator_test
// Drives directed and random allocate, reserve, free and unused-opcode
// requests into the allocator and reports the verdict of the result checker.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_test;
  import bba_pkg::*;

  localparam int               CYCLE_LIMIT  = 100000;
  localparam int               DRAIN_CYCLES = 8;
  localparam logic [OP_W-1:0]  OP_UNUSED    = 2'd3;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  bba_req_t req_i  = '0;
  logic     busy;
  logic     res_valid_o;
  bba_res_t res_o;
  int       mismatch_count;
  int       outstanding;
  int       idle_pct = 0;

  always #1 clk_i = ~clk_i;

  block_bitmap_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  bba_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .req_i          (req_i),
    .busy           (busy),
    .res_valid_o    (res_valid_o),
    .res_o          (res_o),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // Holds a request until it is taken, then idles at random. While start is
  // low the request fields carry junk that the block must ignore.
  task automatic issue(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] blk);
    start <= 1'b1;
    req_i <= '{opcode: op, block_index: blk};
    do @(posedge clk_i); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      req_i <= bba_req_t'($urandom);
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // About half of the traffic aims at the low blocks where allocation happens, so
  // frees and reserves often hit blocks that are in use.
  task automatic issue_random();
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] blk;
    int               pick;
    pick = $urandom_range(99);
    if (pick < 40) op = OP_ALLOC;
    else if (pick < 68) op = OP_FREE;
    else if (pick < 92) op = OP_RESERVE;
    else op = OP_UNUSED;
    if ($urandom_range(1) == 0) blk = IDX_W'($urandom_range(191));
    else blk = IDX_W'($urandom);
    issue(op, blk);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests on the fresh map; the clearing pass holds them off.
    idle_pct = 0;
    issue(OP_ALLOC, 13'd0);
    issue(OP_ALLOC, 13'd8191);
    issue(OP_RESERVE, 13'd2);
    issue(OP_ALLOC, 13'd0);
    issue(OP_RESERVE, 13'd2);
    issue(OP_FREE, 13'd0);
    issue(OP_FREE, 13'd0);
    issue(OP_ALLOC, 13'd4096);
    issue(OP_RESERVE, 13'd8191);
    issue(OP_RESERVE, 13'd8191);
    issue(OP_FREE, 13'd8191);
    issue(OP_FREE, 13'd8191);
    for (int b = 4; b < 8; b++) begin
      issue(OP_RESERVE, IDX_W'(b));
    end
    issue(OP_ALLOC, 13'd0);
    issue(OP_UNUSED, 13'd0);
    issue(OP_UNUSED, 13'd8191);
    issue(OP_UNUSED, 13'd5461);
    issue(OP_FREE, 13'd3);
    issue(OP_ALLOC, 13'd2730);
    issue(OP_RESERVE, 13'd1024);
    issue(OP_FREE, 13'd1024);

    idle_pct = 0;
    repeat (400) issue_random();
    idle_pct = 78;
    repeat (400) issue_random();
    idle_pct = 34;
    repeat (350) issue_random();

    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("block_bitmap_allocator regression: pass");
    end else begin
      $display("block_bitmap_allocator regression: fail");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("block_bitmap_allocator regression: fail");
    $finish;
  end

endmodule
